FILE: hw/rtl/dihedral_angle_four_points_top_defines.svh
// assertion macros for the dihedral angle block
// used by dihedral_angle_four_points_top, expects clk and rst_n in scope
`ifndef DIHEDRAL_ANGLE_FOUR_POINTS_TOP_DEFINES_SVH
`define DIHEDRAL_ANGLE_FOUR_POINTS_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define DAFP_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define DAFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/dafp_pkg.sv
// shared constants and tables for the dihedral angle block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dafp_pkg;

  localparam int ROOT_FRAC = 16;
  localparam int NORM_BITS = 30;
  localparam int MUL_CW    = 16;
  localparam int OUT_W     = 17;
  localparam int XW        = NORM_BITS + 4;
  localparam int ZW        = 27;
  localparam int OUT_HALF  = 46080;

  localparam logic signed [ZW-1:0] HALF_TURN = 27'sd11796480;

  // atan(2^-i) in degrees, 2^-16 degree units
  localparam logic signed [ZW-1:0] ATAN_TAB [32] = '{
    27'sd2949120, 27'sd1740967, 27'sd919879, 27'sd466945,
    27'sd234379,  27'sd117304,  27'sd58666,  27'sd29335,
    27'sd14668,   27'sd7334,    27'sd3667,   27'sd1833,
    27'sd917,     27'sd458,     27'sd229,    27'sd115,
    27'sd57,      27'sd29,      27'sd14,     27'sd7,
    27'sd4,       27'sd2,       27'sd1,      27'sd0,
    27'sd0,       27'sd0,       27'sd0,      27'sd0,
    27'sd0,       27'sd0,       27'sd0,      27'sd0
  };

  typedef logic signed [OUT_W-1:0] angle_t;

endpackage

`default_nettype wire

FILE: hw/rtl/dafp_mul.sv
// pipelined signed multiplier, one 16-bit slice of b per stage
// depends on dafp_pkg
`timescale 1ns / 1ps
`default_nettype none

module dafp_mul #(
  parameter int AW = 8,
  parameter int BW = 8,
  parameter int SW = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 vld_i,
  input  logic signed [AW-1:0] a_i,
  input  logic signed [BW-1:0] b_i,
  input  logic [SW-1:0]        side_i,
  output logic                 vld_o,
  output logic signed [AW+BW-1:0] p_o,
  output logic [SW-1:0]        side_o
);
  import dafp_pkg::*;

  localparam int NC  = (BW + MUL_CW - 1) / MUL_CW;
  localparam int BXW = NC * MUL_CW;
  localparam int PW  = AW + BW;

  logic signed [AW-1:0]  a_r    [NC];
  logic signed [BXW-1:0] b_r    [NC];
  logic signed [PW-1:0]  acc_r  [NC];
  logic [SW-1:0]         side_r [NC];
  logic                  vld_r  [NC];
  logic signed [BXW-1:0] b_ext;

  assign b_ext = BXW'(b_i);

  for (genvar k = 0; k < NC; k++) begin : g_stage
    logic signed [AW-1:0]     a_in;
    logic signed [BXW-1:0]    b_in;
    logic signed [PW-1:0]     acc_in;
    logic [SW-1:0]            side_in;
    logic                     vld_in;
    logic signed [MUL_CW:0]   chunk;
    logic signed [AW+MUL_CW:0] part;
    logic signed [PW-1:0]     part_sh;

    if (k == 0) begin : g_first
      assign a_in    = a_i;
      assign b_in    = b_ext;
      assign acc_in  = '0;
      assign side_in = side_i;
      assign vld_in  = vld_i;
    end else begin : g_next
      assign a_in    = a_r[k-1];
      assign b_in    = b_r[k-1];
      assign acc_in  = acc_r[k-1];
      assign side_in = side_r[k-1];
      assign vld_in  = vld_r[k-1];
    end

    // top slice carries the sign, the others are unsigned
    if (k == NC - 1) begin : g_top
      assign chunk = {b_in[BXW-1], b_in[k*MUL_CW +: MUL_CW]};
    end else begin : g_low
      assign chunk = {1'b0, b_in[k*MUL_CW +: MUL_CW]};
    end

    assign part    = a_in * chunk;
    assign part_sh = PW'(part) <<< (k * MUL_CW);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        a_r[k]    <= a_in;
        b_r[k]    <= b_in;
        acc_r[k]  <= acc_in + part_sh;
        side_r[k] <= side_in;
      end
    end
  end

  assign vld_o  = vld_r[NC-1];
  assign p_o    = acc_r[NC-1];
  assign side_o = side_r[NC-1];

endmodule

`default_nettype wire

FILE: hw/rtl/dafp_sqrt.sv
// pipelined integer square root of sq * 2^(2*ROOT_FRAC), one root bit per stage
// depends on dafp_pkg
`timescale 1ns / 1ps
`default_nettype none

module dafp_sqrt #(
  parameter int SQW = 42,
  parameter int SW  = 1
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               vld_i,
  input  logic [SQW-1:0]                     sq_i,
  input  logic [SW-1:0]                      side_i,
  output logic                               vld_o,
  output logic [SQW/2+dafp_pkg::ROOT_FRAC-1:0] root_o,
  output logic [SW-1:0]                      side_o
);
  import dafp_pkg::*;

  localparam int RADW = SQW + 2 * ROOT_FRAC;
  localparam int RTW  = RADW / 2;
  localparam int REMW = RTW + 3;

  logic [SQW-1:0]  sq_r   [RTW];
  logic [REMW-1:0] rem_r  [RTW];
  logic [RTW-1:0]  root_r [RTW];
  logic [SW-1:0]   side_r [RTW];
  logic            vld_r  [RTW];

  for (genvar k = 0; k < RTW; k++) begin : g_stage
    logic [SQW-1:0]  sq_in;
    logic [REMW-1:0] rem_in;
    logic [RTW-1:0]  root_in;
    logic [SW-1:0]   side_in;
    logic            vld_in;
    logic [RADW-1:0] rad;
    logic [REMW-1:0] rem_sh;
    logic [REMW-1:0] trial;
    logic            ge;

    if (k == 0) begin : g_first
      assign sq_in   = sq_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = side_i;
      assign vld_in  = vld_i;
    end else begin : g_next
      assign sq_in   = sq_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign side_in = side_r[k-1];
      assign vld_in  = vld_r[k-1];
    end

    assign rad    = {sq_in, {(2*ROOT_FRAC){1'b0}}};
    assign rem_sh = {rem_in[REMW-3:0], rad[RADW-1-2*k -: 2]};
    assign trial  = REMW'({root_in, 2'b01});
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_r[k]   <= sq_in;
        rem_r[k]  <= ge ? (rem_sh - trial) : rem_sh;
        root_r[k] <= {root_in[RTW-2:0], ge};
        side_r[k] <= side_in;
      end
    end
  end

  assign vld_o  = vld_r[RTW-1];
  assign root_o = root_r[RTW-1];
  assign side_o = side_r[RTW-1];

endmodule

`default_nettype wire

FILE: hw/rtl/dihedral_angle_four_points_top.sv
// dihedral (torsion) angle of four 3d points, fully pipelined
// depends on dafp_pkg, dafp_mul, dafp_sqrt and the defines header
//
// usage:
//   input channel in_valid/in_ready carries the twelve point coordinates,
//   two's complement, 1/1024 unit. result channel out_valid/out_ready carries
//   out_torsion_deg, the signed angle in 1/256 degree, range (-180, 180],
//   zero when the points are degenerate.
// throughput: one transaction per cycle on both sides unless stalled.
// pipeline, in order: stages 0 to 2, LM dot product multiplier slices, stage 3,
//   RT square root stages (one root bit each), LS sine scaling slices, stage 4,
//   NB normalize shift stages, pre-rotation, cordic stages, output register;
//   LM = ceil((2*COORD_BITS+3)/16), RT = COORD_BITS+17,
//   LS = ceil((COORD_BITS+18)/16), NB = log2 of the widest term.
// stall: the whole pipe shares one advance enable; when the output register
//   holds a transaction that is not taken, every stage holds and in_ready
//   drops in the same cycle, so nothing is lost or repeated.
// reset: synchronous, active low; clears all valid bits, the pipe is then
//   empty and in_ready is high.
`timescale 1ns / 1ps
`default_nettype none
`include "dihedral_angle_four_points_top_defines.svh"

module dihedral_angle_four_points_top #(
  parameter int COORD_BITS   = 20,
  parameter int CORDIC_STEPS = 18
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_BITS-1:0] in_p1_x,
  input  logic signed [COORD_BITS-1:0] in_p1_y,
  input  logic signed [COORD_BITS-1:0] in_p1_z,
  input  logic signed [COORD_BITS-1:0] in_p2_x,
  input  logic signed [COORD_BITS-1:0] in_p2_y,
  input  logic signed [COORD_BITS-1:0] in_p2_z,
  input  logic signed [COORD_BITS-1:0] in_p3_x,
  input  logic signed [COORD_BITS-1:0] in_p3_y,
  input  logic signed [COORD_BITS-1:0] in_p3_z,
  input  logic signed [COORD_BITS-1:0] in_p4_x,
  input  logic signed [COORD_BITS-1:0] in_p4_y,
  input  logic signed [COORD_BITS-1:0] in_p4_z,
  output logic                         out_valid,
  input  logic                         out_ready,
  output dafp_pkg::angle_t             out_torsion_deg
);
  import dafp_pkg::*;

  localparam int DW   = COORD_BITS + 1;          // bond vector component
  localparam int PW   = 2 * DW;                  // single product
  localparam int NW   = PW + 1;                  // normal component
  localparam int SQW  = 2 * COORD_BITS + 2;      // |v|^2
  localparam int MWP  = NW + DW;
  localparam int MW_W = MWP + 2;                 // n1 . r3
  localparam int MKP  = 2 * NW;
  localparam int CS_W = MKP + 2;                 // n1 . n2
  localparam int RTW  = SQW / 2 + ROOT_FRAC;     // |v| * 2^16
  localparam int SN_W = MW_W + RTW + 1;          // sine term
  localparam int VW   = (SN_W > CS_W) ? SN_W : CS_W;
  localparam int NB   = $clog2(VW);
  localparam int RW   = ZW - 7;                  // rounded angle
  localparam int SDW  = MW_W + CS_W;

  localparam logic signed [RW-1:0] R_HALF = RW'(OUT_HALF);
  localparam logic signed [RW-1:0] R_TURN = RW'(2 * OUT_HALF);

  // one advance enable for the whole pipe
  logic en;
  logic out_valid_r;
  angle_t out_torsion_deg_r;

  assign en        = !out_valid_r || out_ready;
  assign in_ready  = en;
  assign out_valid = out_valid_r;
  assign out_torsion_deg = out_torsion_deg_r;

  // ---------------------------------------------------------------------
  // stage 0: bond vectors r1 = p2-p1, r2 = p3-p2, r3 = p4-p3
  // ---------------------------------------------------------------------
  logic signed [DW-1:0] u_nxt [3], v_nxt [3], w_nxt [3];
  logic signed [DW-1:0] u_r [3], v_r [3], w_r [3];
  logic                 vld0_r;

  assign u_nxt[0] = DW'(in_p2_x) - DW'(in_p1_x);
  assign u_nxt[1] = DW'(in_p2_y) - DW'(in_p1_y);
  assign u_nxt[2] = DW'(in_p2_z) - DW'(in_p1_z);
  assign v_nxt[0] = DW'(in_p3_x) - DW'(in_p2_x);
  assign v_nxt[1] = DW'(in_p3_y) - DW'(in_p2_y);
  assign v_nxt[2] = DW'(in_p3_z) - DW'(in_p2_z);
  assign w_nxt[0] = DW'(in_p4_x) - DW'(in_p3_x);
  assign w_nxt[1] = DW'(in_p4_y) - DW'(in_p3_y);
  assign w_nxt[2] = DW'(in_p4_z) - DW'(in_p3_z);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else if (en) begin
      vld0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u_r <= u_nxt;
      v_r <= v_nxt;
      w_r <= w_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // stage 1: cross product terms and squares of r2
  // ---------------------------------------------------------------------
  logic signed [PW-1:0] pm_a_r [3], pm_b_r [3], pk_a_r [3], pk_b_r [3], sqp_r [3];
  logic signed [DW-1:0] w1_r [3];
  logic                 vld1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else if (en) begin
      vld1_r <= vld0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        pm_a_r[j] <= u_r[(j+1)%3] * v_r[(j+2)%3];
        pm_b_r[j] <= u_r[(j+2)%3] * v_r[(j+1)%3];
        pk_a_r[j] <= v_r[(j+1)%3] * w_r[(j+2)%3];
        pk_b_r[j] <= v_r[(j+2)%3] * w_r[(j+1)%3];
        sqp_r[j]  <= v_r[j] * v_r[j];
      end
      w1_r <= w_r;
    end
  end

  // ---------------------------------------------------------------------
  // stage 2: normals n1, n2 and |r2|^2
  // ---------------------------------------------------------------------
  logic signed [NW-1:0] m2_r [3], k2_r [3];
  logic signed [DW-1:0] w2_r [3];
  logic [SQW-1:0]       sq2_r;
  logic                 vld2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
    end else if (en) begin
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < 3; j++) begin
        m2_r[j] <= NW'(pm_a_r[j]) - NW'(pm_b_r[j]);
        k2_r[j] <= NW'(pk_a_r[j]) - NW'(pk_b_r[j]);
      end
      sq2_r <= $unsigned(sqp_r[0]) + $unsigned(sqp_r[1]) + $unsigned(sqp_r[2]);
      w2_r  <= w1_r;
    end
  end

  // ---------------------------------------------------------------------
  // sliced multipliers for n1 . r3 and n1 . n2, |r2|^2 rides alongside
  // ---------------------------------------------------------------------
  logic signed [MWP-1:0] mwp [3];
  logic signed [MKP-1:0] mkp [3];
  logic                  mw_vld;
  logic [SQW-1:0]        mw_sq;

  dafp_mul #(.AW(DW), .BW(NW), .SW(SQW)) u_mw0 (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (vld2_r),
    .a_i    (w2_r[0]),
    .b_i    (m2_r[0]),
    .side_i (sq2_r),
    .vld_o  (mw_vld),
    .p_o    (mwp[0]),
    .side_o (mw_sq)
  );

  for (genvar j = 1; j < 3; j++) begin : g_mw
    dafp_mul #(.AW(DW), .BW(NW), .SW(1)) u_mw (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .vld_i  (vld2_r),
      .a_i    (w2_r[j]),
      .b_i    (m2_r[j]),
      .side_i (1'b0),
      .vld_o  (),
      .p_o    (mwp[j]),
      .side_o ()
    );
  end

  for (genvar j = 0; j < 3; j++) begin : g_mk
    dafp_mul #(.AW(NW), .BW(NW), .SW(1)) u_mk (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en),
      .vld_i  (vld2_r),
      .a_i    (k2_r[j]),
      .b_i    (m2_r[j]),
      .side_i (1'b0),
      .vld_o  (),
      .p_o    (mkp[j]),
      .side_o ()
    );
  end

  // ---------------------------------------------------------------------
  // stage 3: dot product sums
  // ---------------------------------------------------------------------
  logic signed [MW_W-1:0] mw3_r;
  logic signed [CS_W-1:0] cs3_r;
  logic [SQW-1:0]         sq3_r;
  logic                   vld3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld3_r <= 1'b0;
    end else if (en) begin
      vld3_r <= mw_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mw3_r <= MW_W'(mwp[0]) + MW_W'(mwp[1]) + MW_W'(mwp[2]);
      cs3_r <= CS_W'(mkp[0]) + CS_W'(mkp[1]) + CS_W'(mkp[2]);
      sq3_r <= mw_sq;
    end
  end

  // ---------------------------------------------------------------------
  // |r2| * 2^16 by a bit-per-stage root, dot products ride alongside
  // ---------------------------------------------------------------------
  logic           rt_vld;
  logic [RTW-1:0] rt_root;
  logic [SDW-1:0] rt_side;

  dafp_sqrt #(.SQW(SQW), .SW(SDW)) u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (vld3_r),
    .sq_i   (sq3_r),
    .side_i ({mw3_r, cs3_r}),
    .vld_o  (rt_vld),
    .root_o (rt_root),
    .side_o (rt_side)
  );

  // sine term = (n1 . r3) * |r2|
  logic                   sn_vld;
  logic signed [SN_W-1:0] sn;
  logic [CS_W-1:0]        sn_cs;

  dafp_mul #(.AW(MW_W), .BW(RTW+1), .SW(CS_W)) u_sn (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (rt_vld),
    .a_i    ($signed(rt_side[SDW-1 -: MW_W])),
    .b_i    ($signed({1'b0, rt_root})),
    .side_i (rt_side[CS_W-1:0]),
    .vld_o  (sn_vld),
    .p_o    (sn),
    .side_o (sn_cs)
  );

  // ---------------------------------------------------------------------
  // stage 4: signs and magnitudes, degenerate flag
  // ---------------------------------------------------------------------
  logic signed [CS_W-1:0] cs_s;
  logic [VW-1:0]          ms_nxt, mc_nxt;
  logic [VW-1:0]          ms4_r, mc4_r;
  logic                   ns4_r, nc4_r, zero4_r, vld4_r;

  assign cs_s   = $signed(sn_cs);
  assign ms_nxt = VW'($unsigned(sn[SN_W-1] ? -sn : sn));
  assign mc_nxt = VW'($unsigned(cs_s[CS_W-1] ? -cs_s : cs_s));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld4_r <= 1'b0;
    end else if (en) begin
      vld4_r <= sn_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ms4_r   <= ms_nxt;
      mc4_r   <= mc_nxt;
      ns4_r   <= sn[SN_W-1];
      nc4_r   <= cs_s[CS_W-1];
      zero4_r <= ~|(ms_nxt | mc_nxt);
    end
  end

  // ---------------------------------------------------------------------
  // normalize: shift both terms right until the larger fits in 30 bits,
  // one binary shift weight per stage, largest first
  // ---------------------------------------------------------------------
  logic [VW-1:0] nm_ms_r [NB], nm_mc_r [NB];
  logic          nm_ns_r [NB], nm_nc_r [NB], nm_zero_r [NB], nm_vld_r [NB];

  for (genvar q = 0; q < NB; q++) begin : g_norm
    localparam int SH = 2 ** (NB - 1 - q);
    logic [VW-1:0] ms_in, mc_in, both;
    logic          ns_in, nc_in, zero_in, vld_in, big;

    if (q == 0) begin : g_first
      assign ms_in   = ms4_r;
      assign mc_in   = mc4_r;
      assign ns_in   = ns4_r;
      assign nc_in   = nc4_r;
      assign zero_in = zero4_r;
      assign vld_in  = vld4_r;
    end else begin : g_next
      assign ms_in   = nm_ms_r[q-1];
      assign mc_in   = nm_mc_r[q-1];
      assign ns_in   = nm_ns_r[q-1];
      assign nc_in   = nm_nc_r[q-1];
      assign zero_in = nm_zero_r[q-1];
      assign vld_in  = nm_vld_r[q-1];
    end

    assign both = ms_in | mc_in;
    assign big  = |(both >> (NORM_BITS - 1 + SH));

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        nm_vld_r[q] <= 1'b0;
      end else if (en) begin
        nm_vld_r[q] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        nm_ms_r[q]   <= big ? (ms_in >> SH) : ms_in;
        nm_mc_r[q]   <= big ? (mc_in >> SH) : mc_in;
        nm_ns_r[q]   <= ns_in;
        nm_nc_r[q]   <= nc_in;
        nm_zero_r[q] <= zero_in;
      end
    end
  end

  // ---------------------------------------------------------------------
  // pre-rotation: a negative cosine turns the vector by a half turn
  // ---------------------------------------------------------------------
  logic signed [XW-1:0] xm, ym, xs0, ys0;
  logic signed [ZW-1:0] zs0;
  logic signed [XW-1:0] xp_r, yp_r;
  logic signed [ZW-1:0] zp_r;
  logic                 zerop_r, vldp_r;

  assign xm = $signed(XW'(nm_mc_r[NB-1][NORM_BITS-1:0]));
  assign ym = $signed(XW'(nm_ms_r[NB-1][NORM_BITS-1:0]));

  always_comb begin
    xs0 = nm_nc_r[NB-1] ? -xm : xm;
    ys0 = nm_ns_r[NB-1] ? -ym : ym;
    zs0 = '0;
    if (xs0 < 0) begin
      zs0 = (ys0 >= 0) ? HALF_TURN : -HALF_TURN;
      xs0 = -xs0;
      ys0 = -ys0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vldp_r <= 1'b0;
    end else if (en) begin
      vldp_r <= nm_vld_r[NB-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xp_r    <= xs0;
      yp_r    <= ys0;
      zp_r    <= zs0;
      zerop_r <= nm_zero_r[NB-1];
    end
  end

  // ---------------------------------------------------------------------
  // vectoring cordic, one micro-rotation per stage
  // ---------------------------------------------------------------------
  logic signed [XW-1:0] cx_r [CORDIC_STEPS], cy_r [CORDIC_STEPS];
  logic signed [ZW-1:0] cz_r [CORDIC_STEPS];
  logic                 czero_r [CORDIC_STEPS], cvld_r [CORDIC_STEPS];

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    logic signed [XW-1:0] x_in, y_in, x_sh, y_sh;
    logic signed [ZW-1:0] z_in;
    logic                 zero_in, vld_in;

    if (i == 0) begin : g_first
      assign x_in    = xp_r;
      assign y_in    = yp_r;
      assign z_in    = zp_r;
      assign zero_in = zerop_r;
      assign vld_in  = vldp_r;
    end else begin : g_next
      assign x_in    = cx_r[i-1];
      assign y_in    = cy_r[i-1];
      assign z_in    = cz_r[i-1];
      assign zero_in = czero_r[i-1];
      assign vld_in  = cvld_r[i-1];
    end

    assign x_sh = x_in >>> i;
    assign y_sh = y_in >>> i;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cvld_r[i] <= 1'b0;
      end else if (en) begin
        cvld_r[i] <= vld_in;
      end
    end

    // clockwise while y is above the axis
    always_ff @(posedge clk) begin
      if (en) begin
        if (y_in > 0) begin
          cx_r[i] <= x_in + y_sh;
          cy_r[i] <= y_in - x_sh;
          cz_r[i] <= z_in + ATAN_TAB[i];
        end else begin
          cx_r[i] <= x_in - y_sh;
          cy_r[i] <= y_in + x_sh;
          cz_r[i] <= z_in - ATAN_TAB[i];
        end
        czero_r[i] <= zero_in;
      end
    end
  end

  // ---------------------------------------------------------------------
  // output register: round to 1/256 degree and wrap into (-180, 180]
  // ---------------------------------------------------------------------
  logic signed [ZW:0]   rsum;
  logic signed [RW-1:0] rnd, rwrap;
  angle_t               out_nxt;

  always_comb begin
    rsum  = (ZW+1)'(cz_r[CORDIC_STEPS-1]) + (ZW+1)'(128);
    rnd   = rsum[ZW:8];
    rwrap = rnd;
    if (rnd > R_HALF) begin
      rwrap = rnd - R_TURN;
    end else if (rnd <= -R_HALF) begin
      rwrap = rnd + R_TURN;
    end
    out_nxt = czero_r[CORDIC_STEPS-1] ? angle_t'(0) : rwrap[OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= cvld_r[CORDIC_STEPS-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_torsion_deg_r <= out_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  `DAFP_ASSERT(a_stall_holds_input, out_valid && !out_ready, !in_ready, "input taken during stall")
  `DAFP_ASSERT_NEXT(a_accept_enters, in_valid && in_ready, vld0_r, "accepted transaction lost")
  `DAFP_ASSERT(a_norm_fits, nm_vld_r[NB-1] && !nm_zero_r[NB-1], ((nm_ms_r[NB-1] | nm_mc_r[NB-1]) >> NORM_BITS) == '0, "normalize left bits above range")
  `DAFP_ASSERT(a_out_range, out_valid, (out_torsion_deg > -angle_t'(OUT_HALF)) && (out_torsion_deg <= angle_t'(OUT_HALF)), "angle out of range")

endmodule

`default_nettype wire
